[src/rgb_to_xterm256_color_unit_macros.svh]
// Assertion macros for the RGB to xterm-256 color unit.
// Included by the top level; needs a signal named clock and one named reset in scope.
`ifndef RGB_TO_XTERM256_COLOR_UNIT_MACROS_SVH
`define RGB_TO_XTERM256_COLOR_UNIT_MACROS_SVH

// Checked on every rising clock edge, off while reset is high.
`define RXC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define RXC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/rxc_pkg.sv]
// Shared types, constants and helper functions of the RGB to xterm-256 color unit.
// No dependencies.
`timescale 1ns / 1ps

package rxc_pkg;

   localparam int CHAN_W  = 8;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int ERR_W   = SQ_W + 2;
   localparam int SUM_W   = 18;
   localparam int EIGHT_W = SUM_W - 3;
   localparam int RECIP_W = 16;
   localparam int PROD_W  = EIGHT_W + RECIP_W;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [2:0]        cube_idx_type;
   typedef logic [4:0]        step_type;
   typedef logic [SQ_W-1:0]   sq_type;
   typedef logic [ERR_W-1:0]  err_type;

   // luma weights in thousandths, plus half a unit for rounding
   localparam logic [SUM_W-1:0] W_RED      = SUM_W'(299);
   localparam logic [SUM_W-1:0] W_GREEN    = SUM_W'(587);
   localparam logic [SUM_W-1:0] W_BLUE     = SUM_W'(114);
   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(500);

   // x/1000 == (x>>3)/125; (y*33555)>>22 is exact for y < 2^15
   localparam logic [RECIP_W-1:0] RECIP_125   = RECIP_W'(33555);
   localparam int                 RECIP_SHIFT = 22;

   // (x*205)>>11 == x/10 for x < 1024
   localparam logic [SQ_W-1:0] RECIP_10   = SQ_W'(205);
   localparam int              RECIP10_SH = 11;

   localparam chan_type GRAY_LUMA_MAX  = 8'd238;
   localparam chan_type GRAY_LUMA_MIN  = 8'd3;
   localparam step_type GRAY_STEP_TOP  = 5'd23;
   localparam chan_type GRAY_LEVEL_LO  = 8'd8;
   localparam chan_type GRAY_LEVEL_INC = 8'd10;
   localparam chan_type GRAY_BASE      = 8'd232;
   localparam chan_type CUBE_BASE      = 8'd16;
   localparam chan_type CUBE_R_STRIDE  = 8'd36;
   localparam chan_type CUBE_G_STRIDE  = 8'd6;

   // nearest cube coordinate of one channel
   function automatic cube_idx_type cube_index(input chan_type c);
      cube_idx_type i;
      if (c < 8'd48)       i = 3'd0;
      else if (c < 8'd115) i = 3'd1;
      else if (c < 8'd155) i = 3'd2;
      else if (c < 8'd195) i = 3'd3;
      else if (c < 8'd235) i = 3'd4;
      else                 i = 3'd5;
      return i;
   endfunction

   function automatic chan_type cube_level(input cube_idx_type i);
      chan_type l;
      case (i)
         3'd0:    l = 8'd0;
         3'd1:    l = 8'd95;
         3'd2:    l = 8'd135;
         3'd3:    l = 8'd175;
         3'd4:    l = 8'd215;
         default: l = 8'd255;
      endcase
      return l;
   endfunction

   function automatic sq_type sq_diff(input chan_type a, input chan_type b);
      chan_type d;
      d = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   // gray ramp step from luma
   function automatic step_type gray_step(input chan_type luma);
      chan_type x;
      sq_type   p;
      step_type s;
      x = luma - GRAY_LUMA_MIN;
      p = SQ_W'(x) * RECIP_10;
      if (luma > GRAY_LUMA_MAX)      s = GRAY_STEP_TOP;
      else if (luma < GRAY_LUMA_MIN) s = 5'd0;
      else                           s = p[RECIP10_SH +: 5];
      return s;
   endfunction

endpackage

[src/rxc_if.sv]
// Valid/ready channel interfaces of the RGB to xterm-256 color unit.
// Depends on rxc_pkg.
`timescale 1ns / 1ps

interface rxc_req_if import rxc_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rxc_rsp_if import rxc_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type color_index;

   modport source (output valid, output color_index, input ready);
   modport sink   (input valid, input color_index, output ready);
endinterface

[src/rgb_to_xterm256_color_unit.sv]
// RGB to xterm-256 color unit: top level.
// Depends on rxc_pkg, rxc_if.sv and rgb_to_xterm256_color_unit_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   req: one pixel per item (red, green, blue, 8 bits each), valid/ready.
//   rsp: one palette index per item (16..231 cube, 232..255 gray ramp).
//   An item is taken at a rising edge with valid and ready both high.
// Path: an item passes the input register, then the result register;
//   rsp.valid rises once the result register has loaded it.
// Throughput: one item per cycle while rsp is taken. The whole conversion
//   (luma, gray step, squared errors, compare) sits between the two registers.
// Stall: when rsp is not taken, the result register holds; the input
//   register still takes one more item, then req.ready drops until the
//   result moves on. No item is lost or repeated.
// Reset: synchronous, active high; clears both valid flags, so the unit
//   comes up empty and ready.
// Luma = (299r + 587g + 114b + 500) / 1000, done as a shift by 3 and a
//   reciprocal multiply by 1/125; the /10 of the gray step is a
//   reciprocal multiply too.
// Cube wins ties with the gray ramp.
//
`include "rgb_to_xterm256_color_unit_macros.svh"

module rgb_to_xterm256_color_unit import rxc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rxc_req_if.sink      req,
   rxc_rsp_if.source    rsp
);

   // pipeline registers
   logic     s1_valid_ff, s1_valid_in;
   chan_type red_ff, red_in;
   chan_type green_ff, green_in;
   chan_type blue_ff, blue_in;
   logic     rsp_valid_ff, rsp_valid_in;
   chan_type color_index_ff, color_index_in;

   logic s2_open;   // result register can load
   logic s1_open;   // input register can load

   // datapath
   logic [SUM_W-1:0]   luma_sum;
   logic [PROD_W-1:0]  luma_prod;
   chan_type           luma;
   step_type           step;
   chan_type           gray_lvl;
   cube_idx_type       ir, ig, ib;
   err_type            cube_err, gray_err;
   chan_type           cube_ix;

   assign s2_open   = !rsp_valid_ff || rsp.ready;
   assign s1_open   = !s1_valid_ff || s2_open;
   assign req.ready = s1_open;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.color_index = color_index_ff;

   // luma, rounded to nearest
   assign luma_sum  = SUM_W'(red_ff) * W_RED + SUM_W'(green_ff) * W_GREEN
                    + SUM_W'(blue_ff) * W_BLUE + ROUND_BIAS;
   assign luma_prod = PROD_W'(luma_sum[SUM_W-1:3]) * PROD_W'(RECIP_125);
   assign luma      = luma_prod[RECIP_SHIFT +: CHAN_W];

   assign step     = gray_step(luma);
   assign gray_lvl = GRAY_LEVEL_LO + CHAN_W'(step) * GRAY_LEVEL_INC;

   assign ir = cube_index(red_ff);
   assign ig = cube_index(green_ff);
   assign ib = cube_index(blue_ff);

   assign cube_err = ERR_W'(sq_diff(cube_level(ir), red_ff))
                   + ERR_W'(sq_diff(cube_level(ig), green_ff))
                   + ERR_W'(sq_diff(cube_level(ib), blue_ff));
   assign gray_err = ERR_W'(sq_diff(gray_lvl, red_ff))
                   + ERR_W'(sq_diff(gray_lvl, green_ff))
                   + ERR_W'(sq_diff(gray_lvl, blue_ff));

   assign cube_ix = CUBE_BASE + CHAN_W'(ir) * CUBE_R_STRIDE
                  + CHAN_W'(ig) * CUBE_G_STRIDE + CHAN_W'(ib);

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      red_in         = red_ff;
      green_in       = green_ff;
      blue_in        = blue_ff;
      rsp_valid_in   = rsp_valid_ff;
      color_index_in = color_index_ff;
      if (s1_open) begin
         s1_valid_in = req.valid;
         if (req.valid) begin
            red_in   = req.red;
            green_in = req.green;
            blue_in  = req.blue;
         end
      end
      if (s2_open) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            // ties go to the cube
            color_index_in = (cube_err <= gray_err) ? cube_ix
                                                    : (GRAY_BASE + CHAN_W'(step));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff         <= red_in;
      green_ff       <= green_in;
      blue_ff        <= blue_in;
      color_index_ff <= color_index_in;
   end

   // both stages full and output stalled: no room for another item
   `RXC_ASSERT(a_full_blocks_req, (s1_valid_ff && rsp_valid_ff && !rsp.ready) |-> !req.ready, "req.ready high with pipeline full and stalled")
   // an item in the input stage moves to the result register when it is open
   `RXC_ASSERT(a_item_advances, (s1_valid_ff && s2_open) |=> rsp_valid_ff, "item dropped between stages")
   // every delivered index lies in the cube or gray ramp
   `RXC_ASSERT(a_index_range, rsp_valid_ff |-> (color_index_ff >= CUBE_BASE), "color index below palette range")

endmodule

[tb/xterm_index_checker.sv]
// Result checker for the RGB to xterm-256 color unit: predicts each palette index and compares.
// Depends on rxc_pkg; it watches the channel signals passed in by the testbench top.
`timescale 1ns / 1ps

module xterm_index_checker import rxc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  chan_type req_red,
   input  chan_type req_green,
   input  chan_type req_blue,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  chan_type rsp_color_index,
   output int       mismatch_count,
   output int       pending_count
);

   localparam int LUMA_TOP_STEP  = 238;
   localparam int LUMA_DARK      = 3;
   localparam int TOP_STEP       = 23;
   localparam int FIRST_CUBE_IDX = 16;
   localparam int FIRST_GRAY_IDX = 232;
   localparam int MAX_PRINTED    = 50;
   localparam int CUBE_LEVELS [6] = '{0, 95, 135, 175, 215, 255};

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      chan_type color_index;
   } pixel_index_type;

   pixel_index_type expected_index_q[$];
   pixel_index_type oldest;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic cube_idx_type cube_coord(input chan_type c);
      if (c < 8'd48)  return 3'd0;
      if (c < 8'd115) return 3'd1;
      return cube_idx_type'((int'(c) - 35) / 40);
   endfunction

   function automatic int sq_err(input int lvl, input chan_type c);
      int d;
      d = lvl - int'(c);
      return d * d;
   endfunction

   // nearest palette entry; cube wins a tie with the gray ramp
   function automatic chan_type nearest_xterm_index(input chan_type r, g, b);
      int unsigned  luma;
      step_type     step;
      cube_idx_type ir, ig, ib;
      int           gray_lvl, cube_err, gray_err;
      luma = (299 * int'(r) + 587 * int'(g) + 114 * int'(b) + 500) / 1000;
      if (luma > LUMA_TOP_STEP)  step = step_type'(TOP_STEP);
      else if (luma < LUMA_DARK) step = '0;
      else                       step = step_type'((luma - LUMA_DARK) / 10);
      ir = cube_coord(r);
      ig = cube_coord(g);
      ib = cube_coord(b);
      gray_lvl = 8 + 10 * int'(step);
      cube_err = sq_err(CUBE_LEVELS[ir], r) + sq_err(CUBE_LEVELS[ig], g)
               + sq_err(CUBE_LEVELS[ib], b);
      gray_err = sq_err(gray_lvl, r) + sq_err(gray_lvl, g) + sq_err(gray_lvl, b);
      if (cube_err <= gray_err)
         return chan_type'(FIRST_CUBE_IDX + 36 * int'(ir) + 6 * int'(ig) + int'(ib));
      return chan_type'(FIRST_GRAY_IDX + int'(step));
   endfunction

   task automatic report_mismatch(input string what, input pixel_index_type px,
                                  input chan_type got);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t: %s: pixel (%0d,%0d,%0d) expected index %0d, got %0d", $time, what,
                  px.red, px.green, px.blue, px.color_index, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_index_q.size() == 0) begin
               report_mismatch("index with no pixel pending", '0, rsp_color_index);
            end else begin
               oldest = expected_index_q.pop_front();
               if (rsp_color_index !== oldest.color_index)
                  report_mismatch("color_index", oldest, rsp_color_index);
            end
         end
         if (req_valid && req_ready)
            expected_index_q.push_back({req_red, req_green, req_blue,
                                        nearest_xterm_index(req_red, req_green, req_blue)});
         pending_count = expected_index_q.size();
      end
   end

endmodule

[tb/rgb_to_xterm256_color_unit_tb.sv]
// Testbench top for the RGB to xterm-256 color unit: clock, reset, pixel stimulus, verdict.
// Depends on rxc_pkg, rxc_if.sv, the unit itself and xterm_index_checker.
`timescale 1ns / 1ps

module rgb_to_xterm256_color_unit_tb;
   import rxc_pkg::*;

   localparam int RANDOM_PIXELS = 1600;
   localparam int DRAIN_CYCLES  = 10;   // well past the trip through both unit registers

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;

   rxc_req_if req_ch ();
   rxc_rsp_if rsp_ch ();

   rgb_to_xterm256_color_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // The checker sees every handshake and owns the whole prediction;
   // this module only makes traffic and reads back the two counts.
   xterm_index_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_red         (req_ch.red),
      .req_green       (req_ch.green),
      .req_blue        (req_ch.blue),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_color_index (rsp_ch.color_index),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Worst case is roughly 1650 items, each behind the longest gap and the longest
   // stall, about 1.1 ms; allow several times that.
   initial begin
      #5_000_000;
      $display("** rgb_to_xterm256_color_unit: FAILED **");
      $finish;
   end

   // Mostly short gaps, now and then a medium one, rarely a long one.
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(0, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Channel values on or next to the cube decision points and the range ends.
   function automatic chan_type boundary_chan();
      case ($urandom_range(0, 13))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd47;
         3:       return 8'd48;
         4:       return 8'd114;
         5:       return 8'd115;
         6:       return 8'd154;
         7:       return 8'd155;
         8:       return 8'd194;
         9:       return 8'd195;
         10:      return 8'd234;
         11:      return 8'd235;
         12:      return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   // base plus a small offset, clamped: lands near the gray axis
   function automatic chan_type near_chan(input chan_type base);
      int v;
      v = int'(base) + $urandom_range(0, 16) - 8;
      if (v < 0)   v = 0;
      if (v > 255) v = 255;
      return chan_type'(v);
   endfunction

   // Result side: runs of ready broken by stalls, with an occasional long
   // calm run so that back-to-back traffic also gets through.
   initial begin : rsp_backpressure
      int run;
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
         repeat (run) begin
            @(negedge clock);
            rsp_ch.ready = 1'b1;
         end
         stall = gap_len();
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready = 1'b0;
         end
      end
   end

   // Present one pixel at the falling edge and hold it until taken.
   task automatic send_pixel(input chan_type r, input chan_type g, input chan_type b);
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.red   = r;
      req_ch.green = g;
      req_ch.blue  = b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Idle cycles; the payload wanders so stale data is never trusted.
   task automatic idle_req(input int n);
      repeat (n) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         req_ch.red   = chan_type'($urandom);
         req_ch.green = chan_type'($urandom);
         req_ch.blue  = chan_type'($urandom);
      end
   endtask

   // Hold off the sender until every predicted index has come back.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end while (pending_count != 0);
   endtask

   initial begin : pixel_stimulus
      int       i;
      int       kind;
      chan_type base;
      chan_type r, g, b;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.red   = '0;
      req_ch.green = '0;
      req_ch.blue  = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed: range ends, pure primaries, very dark luma, luma at and
      // above the top gray step, cube thresholds, and exact cube/gray ties.
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd2,   8'd2,   8'd2);
      send_pixel(8'd238, 8'd238, 8'd238);
      send_pixel(8'd239, 8'd239, 8'd239);
      send_pixel(8'd245, 8'd240, 8'd250);
      send_pixel(8'd47,  8'd48,  8'd114);
      send_pixel(8'd115, 8'd154, 8'd155);
      send_pixel(8'd194, 8'd195, 8'd234);
      send_pixel(8'd235, 8'd96,  8'd135);
      send_pixel(8'd4,   8'd4,   8'd4);     // tie: cube error 48 = gray error 48
      send_pixel(8'd0,   8'd0,   8'd12);    // tie at 144
      send_pixel(8'd12,  8'd0,   8'd0);     // tie at 144
      send_pixel(8'd91,  8'd92,  8'd90);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd170, 8'd85,  8'd0);
      wait_drained();

      // Random: uniform pixels, near-gray pixels (gray ramp and its edges),
      // and pixels with channels on the cube thresholds.
      for (i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == RANDOM_PIXELS / 2)
            wait_drained();
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            r = chan_type'($urandom);
            g = chan_type'($urandom);
            b = chan_type'($urandom);
         end else if (kind < 8) begin
            base = chan_type'($urandom);
            r = near_chan(base);
            g = near_chan(base);
            b = near_chan(base);
         end else begin
            r = boundary_chan();
            g = boundary_chan();
            b = boundary_chan();
         end
         send_pixel(r, g, b);
         // first 40 of every 200 go back to back
         if ((i % 200) >= 40)
            idle_req(gap_len());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("** rgb_to_xterm256_color_unit: PASSED **");
      else
         $display("** rgb_to_xterm256_color_unit: FAILED **");
      $finish;
   end

endmodule
